@@ rtl/imu_offset_calibrate_and_smooth_assert.svh @@
// -----------------------------------------------------------------------------
// IMU calibrate and smooth assertion macros
// Shared forms for the concurrent checks of the calibrate and smooth block.
// -----------------------------------------------------------------------------
`ifndef IMU_OFFSET_CALIBRATE_AND_SMOOTH_ASSERT_SVH
`define IMU_OFFSET_CALIBRATE_AND_SMOOTH_ASSERT_SVH

// Check that is switched off while the reset is held.
`define IOC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through the reset.
`define IOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ioc_pkg.sv @@
// -----------------------------------------------------------------------------
// IMU calibrate and smooth package
// Word formats, register map and fixed constants of the calibrate and smooth
// block.
// -----------------------------------------------------------------------------
`default_nettype none

package ioc_pkg;

  // Input word: one raw sample plus the two calibration requests.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] temp_raw;
    logic               start_accel_cal;
    logic               start_rate_cal;
  } in_word_t;

  // Result word: window means in Q15.4, filtered temperature and status.
  typedef struct packed {
    logic signed [19:0] accel_x_mean;
    logic signed [19:0] accel_y_mean;
    logic signed [19:0] accel_z_mean;
    logic signed [19:0] rate_x_mean;
    logic signed [19:0] rate_y_mean;
    logic signed [19:0] rate_z_mean;
    logic signed [15:0] temp_filtered;
    logic               accel_cal_busy;
    logic               rate_cal_busy;
    logic               cal_done;
  } out_word_t;

  // Configuration address map: one 32-bit register per word address.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_TEMP_LPF_GAIN = 1'b0;

  // Reset gain of the temperature low-pass, about 2*pi*T in Q0.16.
  localparam logic [15:0] GAIN_RESET = 16'd2058;

  // One g on the accelerometer z axis.
  localparam logic signed [16:0] ONE_G = 17'sd16384;

endpackage

`default_nettype wire

@@ rtl/ioc_stream_if.sv @@
// -----------------------------------------------------------------------------
// IMU calibrate and smooth stream interface
// Valid/ready channel that carries one word of type T per handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface ioc_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/ioc_ram.sv @@
// -----------------------------------------------------------------------------
// IMU calibrate and smooth RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
`default_nettype none

module ioc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/imu_offset_calibrate_and_smooth.sv @@
// -----------------------------------------------------------------------------
// IMU offset calibrate and smooth: input word to result word. Throughput one word
// per clock while out_ch.ready does not stall it; the input register, calibration
// stage, window stage and result register each hold one word. Synchronous active-low
// reset; the window ring needs no clearing pass, a fill flag masks unwritten slots.
// -----------------------------------------------------------------------------
`default_nettype none

module imu_offset_calibrate_and_smooth #(
  parameter int WINDOW_LEN  = 8,
  parameter int CAL_SAMPLES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ioc_stream_if.sink                           in_ch,
  ioc_stream_if.source                         out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ioc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  // ---------------------------------------------------------------------------
  // Derived sizes and reciprocal constants
  // ---------------------------------------------------------------------------
  localparam int CAL_LG = $clog2(CAL_SAMPLES);
  localparam int CNT_W  = CAL_LG;
  localparam int ACAL_W = 17 + CAL_LG;
  localparam int RCAL_W = 16 + CAL_LG;

  // Truncating division by CAL_SAMPLES: q = (|x| * M) >> S, exact for |x| < 2^N.
  localparam int ADIV_N = ACAL_W - 1;
  localparam int ADIV_S = ADIV_N + CAL_LG;
  localparam longint unsigned ADIV_M =
    ((64'd1 << ADIV_S) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [ADIV_N:0] ADIV_MUL = ADIV_M[ADIV_N:0];
  localparam int AQ_W = 2 * ADIV_N + 1 - ADIV_S;

  localparam int RDIV_N = RCAL_W + 4;
  localparam int RDIV_S = RDIV_N + CAL_LG;
  localparam longint unsigned RDIV_M =
    ((64'd1 << RDIV_S) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RDIV_N:0] RDIV_MUL = RDIV_M[RDIV_N:0];
  localparam int RQ_W = 2 * RDIV_N + 1 - RDIV_S;

  localparam int WIN_LG = $clog2(WINDOW_LEN);
  localparam int POS_W  = WIN_LG;
  localparam int SUM_W  = 16 + WIN_LG;
  localparam int MDIV_N = SUM_W + 4;
  localparam int MDIV_S = MDIV_N + WIN_LG;
  localparam longint unsigned MDIV_M =
    ((64'd1 << MDIV_S) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [MDIV_N:0] MDIV_MUL = MDIV_M[MDIV_N:0];
  localparam int MQ_W = 2 * MDIV_N + 1 - MDIV_S;

  localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
  localparam int RAM_W = 96;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7fff;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r;
  logic fire1, fire2, fire3;
  logic in_acc;

  assign fire3  = v2_r && (!v3_r || out_ch.ready);
  assign fire2  = v1_r && (!v2_r || fire3);
  assign fire1  = v0_r && (!v1_r || fire2);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !v0_r || fire1;
  assign out_ch.valid = v3_r;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic [15:0] gain_r;
  logic        cfg_wr;
  logic [ioc_pkg::CFG_ADDR_W-3:0] cfg_idx;

  assign cfg_idx = paddr[ioc_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = (cfg_idx == ioc_pkg::REG_TEMP_LPF_GAIN) ? {16'd0, gain_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------------
  ioc_pkg::in_word_t d0_r;

  logic signed [15:0] acc1_r   [3];
  logic signed [15:0] gyr1_r   [3];
  logic signed [15:0] abias1_r [3];
  logic signed [19:0] rbias1_r [3];
  logic signed [15:0] temp1_r;
  logic               abusy1_r, rbusy1_r, done1_r;

  logic signed [SUM_W-1:0] wsum2_r [6];
  logic signed [15:0]      temp2_r;
  logic                    abusy2_r, rbusy2_r, done2_r;

  ioc_pkg::out_word_t d3_r;

  assign out_ch.data = d3_r;

  // ---------------------------------------------------------------------------
  // Calibration state and stage 1: accumulate and form new offsets
  // ---------------------------------------------------------------------------
  logic signed [ACAL_W-1:0] a_sum_r [3];
  logic signed [RCAL_W-1:0] r_sum_r [3];
  logic [CNT_W-1:0]         a_count_r, r_count_r;
  logic                     a_active_r, r_active_r;
  logic signed [15:0]       a_bias_r [3];
  logic signed [19:0]       r_bias_r [3];

  logic signed [15:0]       acc0 [3];
  logic signed [15:0]       gyr0 [3];
  logic                     a_act, r_act, a_last, r_last, a_fin, r_fin;
  logic signed [16:0]       a_term    [3];
  logic signed [ACAL_W-1:0] a_sum_new [3];
  logic [ADIV_N-1:0]        a_mag     [3];
  logic [2*ADIV_N:0]        a_prod    [3];
  logic signed [AQ_W:0]     a_qs      [3];
  logic signed [15:0]       a_bias_new[3];
  logic signed [RCAL_W-1:0] r_sum_new [3];
  logic [RCAL_W-1:0]        r_abs     [3];
  logic [RDIV_N-1:0]        r_mag     [3];
  logic [2*RDIV_N:0]        r_prod    [3];
  logic signed [RQ_W:0]     r_qs      [3];
  logic signed [19:0]       r_bias_new[3];

  always_comb begin
    acc0[0] = d0_r.accel_x;
    acc0[1] = d0_r.accel_y;
    acc0[2] = d0_r.accel_z;
    gyr0[0] = d0_r.rate_x;
    gyr0[1] = d0_r.rate_y;
    gyr0[2] = d0_r.rate_z;

    // A request joins a running calibration without restarting it.
    a_act  = a_active_r || d0_r.start_accel_cal;
    r_act  = r_active_r || d0_r.start_rate_cal;
    a_last = (a_count_r == CAL_LAST);
    r_last = (r_count_r == CAL_LAST);
    a_fin  = a_act && a_last;
    r_fin  = r_act && r_last;

    for (int i = 0; i < 3; i++) begin
      a_term[i] = 17'(acc0[i]);
      if (i == 2) begin
        a_term[i] = 17'(acc0[i]) - ioc_pkg::ONE_G;
      end
      a_sum_new[i] = a_sum_r[i] + ACAL_W'(a_term[i]);
      a_mag[i]     = a_sum_new[i][ACAL_W-1] ? ADIV_N'(-a_sum_new[i]) : ADIV_N'(a_sum_new[i]);
      a_prod[i]    = a_mag[i] * ADIV_MUL;
      a_qs[i]      = $signed({1'b0, a_prod[i][2*ADIV_N:ADIV_S]});
      if (a_sum_new[i][ACAL_W-1]) begin
        a_qs[i] = -a_qs[i];
      end
      a_bias_new[i] = sat16(24'(a_qs[i]));

      // The rate offset keeps four fraction bits: divide sum * 16.
      r_sum_new[i] = r_sum_r[i] + RCAL_W'(gyr0[i]);
      r_abs[i]     = r_sum_new[i][RCAL_W-1] ? -r_sum_new[i] : r_sum_new[i];
      r_mag[i]     = {r_abs[i], 4'b0000};
      r_prod[i]    = r_mag[i] * RDIV_MUL;
      r_qs[i]      = $signed({1'b0, r_prod[i][2*RDIV_N:RDIV_S]});
      if (r_sum_new[i][RCAL_W-1]) begin
        r_qs[i] = -r_qs[i];
      end
      r_bias_new[i] = r_qs[i][19:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: offset correction, window ring and temperature low-pass
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    filled_r;
  logic signed [SUM_W-1:0] w_sum_r [6];
  logic signed [31:0]      t_state_r;

  logic [RAM_W-1:0]        ram_rdata;
  logic [RAM_W-1:0]        ram_wdata;
  logic signed [15:0]      corr      [6];
  logic signed [15:0]      old_val   [6];
  logic signed [SUM_W-1:0] wsum_new  [6];
  logic signed [23:0]      a_diff    [3];
  logic signed [23:0]      r_diff    [3];
  logic signed [23:0]      r_quot    [3];
  logic signed [33:0]      t_diff;
  logic signed [50:0]      t_prod;
  logic signed [31:0]      t_state_new;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_diff[i]   = 24'(acc1_r[i]) - 24'(abias1_r[i]);
      corr[i]     = sat16(a_diff[i]);
      r_diff[i]   = (24'(gyr1_r[i]) <<< 4) - 24'(rbias1_r[i]);
      // Divide by 16 rounding toward zero.
      r_quot[i]   = r_diff[i][23] ? ((r_diff[i] + 24'sd15) >>> 4) : (r_diff[i] >>> 4);
      corr[3 + i] = sat16(r_quot[i]);
    end
    for (int i = 0; i < 6; i++) begin
      // Slots not yet written since reset are read as zero through the fill flag.
      old_val[i] = filled_r ? $signed(ram_rdata[16*i +: 16]) : 16'sd0;
      wsum_new[i] = w_sum_r[i] + SUM_W'(corr[i]) - SUM_W'(old_val[i]);
      ram_wdata[16*i +: 16] = corr[i];
    end

    t_diff      = (34'(temp1_r) <<< 16) - 34'(t_state_r);
    t_prod      = t_diff * $signed({1'b0, gain_r});
    t_state_new = t_state_r + t_prod[47:16];
  end

  always_comb begin
    pos_nxt = pos_r;
    if (fire2) begin
      pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
    end
  end

  // The read address runs one slot ahead so the old entry is ready in time.
  ioc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW_LEN)
  ) u_ioc_ram (
    .clk   (clk),
    .we    (fire2),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (pos_nxt),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: window means
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]     m_abs  [6];
  logic [MDIV_N-1:0]    m_mag  [6];
  logic [2*MDIV_N:0]    m_prod [6];
  logic signed [MQ_W:0] m_qs   [6];
  logic signed [19:0]   mean   [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m_abs[i]  = wsum2_r[i][SUM_W-1] ? -wsum2_r[i] : wsum2_r[i];
      m_mag[i]  = {m_abs[i], 4'b0000};
      m_prod[i] = m_mag[i] * MDIV_MUL;
      m_qs[i]   = $signed({1'b0, m_prod[i][2*MDIV_N:MDIV_S]});
      if (wsum2_r[i][SUM_W-1]) begin
        m_qs[i] = -m_qs[i];
      end
      mean[i] = m_qs[i][19:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      gain_r     <= ioc_pkg::GAIN_RESET;
      a_count_r  <= '0;
      r_count_r  <= '0;
      a_active_r <= 1'b0;
      r_active_r <= 1'b0;
      pos_r      <= '0;
      filled_r   <= 1'b0;
      t_state_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        a_sum_r[i]  <= '0;
        r_sum_r[i]  <= '0;
        a_bias_r[i] <= '0;
        r_bias_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        w_sum_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        v0_r <= 1'b1;
      end else if (fire1) begin
        v0_r <= 1'b0;
      end
      if (fire1) begin
        v1_r <= 1'b1;
      end else if (fire2) begin
        v1_r <= 1'b0;
      end
      if (fire2) begin
        v2_r <= 1'b1;
      end else if (fire3) begin
        v2_r <= 1'b0;
      end
      if (fire3) begin
        v3_r <= 1'b1;
      end else if (out_ch.ready) begin
        v3_r <= 1'b0;
      end

      if (cfg_wr && cfg_idx == ioc_pkg::REG_TEMP_LPF_GAIN) begin
        gain_r <= pwdata[15:0];
      end

      if (fire1 && a_act) begin
        if (a_last) begin
          a_count_r  <= '0;
          a_active_r <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            a_sum_r[i]  <= '0;
            a_bias_r[i] <= a_bias_new[i];
          end
        end else begin
          a_count_r  <= a_count_r + 1'b1;
          a_active_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            a_sum_r[i] <= a_sum_new[i];
          end
        end
      end

      if (fire1 && r_act) begin
        if (r_last) begin
          r_count_r  <= '0;
          r_active_r <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            r_sum_r[i]  <= '0;
            r_bias_r[i] <= r_bias_new[i];
          end
        end else begin
          r_count_r  <= r_count_r + 1'b1;
          r_active_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            r_sum_r[i] <= r_sum_new[i];
          end
        end
      end

      pos_r <= pos_nxt;
      if (fire2) begin
        t_state_r <= t_state_new;
        if (pos_r == POS_LAST) begin
          filled_r <= 1'b1;
        end
        for (int i = 0; i < 6; i++) begin
          w_sum_r[i] <= wsum_new[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      d0_r <= in_ch.data;
    end

    if (fire1) begin
      for (int i = 0; i < 3; i++) begin
        acc1_r[i]   <= acc0[i];
        gyr1_r[i]   <= gyr0[i];
        // A completing sample is corrected with the offsets it produced.
        abias1_r[i] <= a_fin ? a_bias_new[i] : a_bias_r[i];
        rbias1_r[i] <= r_fin ? r_bias_new[i] : r_bias_r[i];
      end
      temp1_r  <= d0_r.temp_raw;
      abusy1_r <= a_act && !a_last;
      rbusy1_r <= r_act && !r_last;
      done1_r  <= a_fin || r_fin;
    end

    if (fire2) begin
      for (int i = 0; i < 6; i++) begin
        wsum2_r[i] <= wsum_new[i];
      end
      temp2_r  <= t_state_new[31:16];
      abusy2_r <= abusy1_r;
      rbusy2_r <= rbusy1_r;
      done2_r  <= done1_r;
    end

    if (fire3) begin
      d3_r.accel_x_mean   <= mean[0];
      d3_r.accel_y_mean   <= mean[1];
      d3_r.accel_z_mean   <= mean[2];
      d3_r.rate_x_mean    <= mean[3];
      d3_r.rate_y_mean    <= mean[4];
      d3_r.rate_z_mean    <= mean[5];
      d3_r.temp_filtered  <= temp2_r;
      d3_r.accel_cal_busy <= abusy2_r;
      d3_r.rate_cal_busy  <= rbusy2_r;
      d3_r.cal_done       <= done2_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ioc_checker.sv @@
// -----------------------------------------------------------------------------
// IMU calibrate and smooth port checker
// Concurrent checks on the result channel and the configuration port.
// -----------------------------------------------------------------------------
`default_nettype none

`include "imu_offset_calibrate_and_smooth_assert.svh"

module ioc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire ioc_pkg::out_word_t             out_data,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [ioc_pkg::CFG_ADDR_W-1:0] paddr,
  input wire logic [31:0]                    pwdata,
  input wire logic [31:0]                    prdata,
  input wire logic                           pready
);

  // A reset leaves no result word pending.
  `IOC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

  `IOC_ASSERT(a_out_hold, clk, rst_n, rst_n && out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result word changed")

  // A sample that ends a calibration cannot leave both calibrations running.
  `IOC_ASSERT(a_done_busy, clk, rst_n, out_valid && out_data.cal_done |-> !(out_data.accel_cal_busy && out_data.rate_cal_busy), "calibration done while both busy")

  `IOC_ASSERT(a_gain_readback, clk, rst_n, rst_n && psel && penable && pwrite && pready && paddr[ioc_pkg::CFG_ADDR_W-1:2] == ioc_pkg::REG_TEMP_LPF_GAIN |=> paddr[ioc_pkg::CFG_ADDR_W-1:2] != ioc_pkg::REG_TEMP_LPF_GAIN || prdata[15:0] == $past(pwdata[15:0]), "gain register readback mismatch")

endmodule

bind imu_offset_calibrate_and_smooth ioc_checker u_ioc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

`default_nettype wire
